@@ design/vrz_pkg.sv @@
package vrz_pkg;

  localparam int LEAF_W = 13;
  localparam logic [7:0] FILL_BYTE = 8'hff;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [63:0] vis_word;
    logic [5:0]  word_index;
    logic        row_last;
  } result_t;

  localparam logic [1:0] CMD_LIT  = 2'd0;
  localparam logic [1:0] CMD_ZERO = 2'd1;
  localparam logic [1:0] CMD_FILL = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } cmd_t;

endpackage

@@ design/vrz_front.sv @@
module vrz_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  logic          push,
  input  vrz_pkg::item_t item,
  output logic          full,
  input  logic          q_full,
  output logic          q_push,
  output vrz_pkg::cmd_t q_cmd
);
  import vrz_pkg::*;

  logic count_expected;
  logic count_expected_next;
  logic accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    q_push              = 1'b0;
    q_cmd.kind          = CMD_LIT;
    q_cmd.value         = item.data_byte;
    count_expected_next = count_expected;
    if (accept) begin
      priority if (item.mode) begin
        q_push              = 1'b1;
        q_cmd.kind          = CMD_FILL;
        count_expected_next = 1'b0;
      end else if (count_expected) begin
        count_expected_next = 1'b0;
        if (item.data_byte != 8'd0) begin
          q_push     = 1'b1;
          q_cmd.kind = CMD_ZERO;
        end
      end else if (item.data_byte == 8'd0) begin
        count_expected_next = 1'b1;
      end else begin
        q_push     = 1'b1;
        q_cmd.kind = CMD_LIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count_expected <= 1'b0;
    end else begin
      count_expected <= count_expected_next;
    end
  end

endmodule

@@ design/vrz_cmd_queue.sv @@
module vrz_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  vrz_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd,
  output vrz_pkg::cmd_t rd_cmd,
  output logic          empty
);
  import vrz_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;
  assign rd_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

endmodule

@@ design/vrz_back.sv @@
module vrz_back #(
  parameter int MAX_ROW_BYTES = 512
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  clear,
  input  logic [$clog2(MAX_ROW_BYTES+1)-1:0]    row_bytes,
  input  logic                                  q_empty,
  input  vrz_pkg::cmd_t                         q_cmd,
  output logic                                  q_pop,
  output logic                                  empty,
  input  logic                                  pop,
  output vrz_pkg::result_t                      result
);
  import vrz_pkg::*;

  localparam int PW = $clog2(MAX_ROW_BYTES + 1);
  localparam int CW = (PW > 8) ? PW : 8;

  logic          active;
  logic [1:0]    kind;
  logic [7:0]    value;
  logic [CW-1:0] cnt;
  logic [PW-1:0] bytes_out;
  logic [63:0]   word_buffer;
  logic          out_valid;
  result_t       out_word;

  logic [2:0]    off;
  logic [3:0]    room;
  logic [PW-1:0] remain;
  logic [CW-1:0] take_w;
  logic [3:0]    take;
  logic [3:0]    span_end;
  logic [PW-1:0] new_pos;
  logic          last;
  logic          emit;
  logic [63:0]   ins;
  logic [63:0]   word_new;
  logic          slot_free;
  logic          step;
  logic          load;
  logic [CW-1:0] cnt_rem;
  logic [PW+5:0] pos_ext;

  assign off      = bytes_out[2:0];
  assign room     = 4'd8 - {1'b0, off};
  assign remain   = row_bytes - bytes_out;

  always_comb begin
    take_w = cnt;
    if (CW'(room) < take_w) begin
      take_w = CW'(room);
    end
    if (CW'(remain) < take_w) begin
      take_w = CW'(remain);
    end
  end

  assign take     = take_w[3:0];
  assign span_end = {1'b0, off} + take;
  assign new_pos  = bytes_out + PW'(take);
  assign last     = (new_pos == row_bytes);
  assign emit     = (new_pos[2:0] == 3'd0) || last;
  assign cnt_rem  = cnt - CW'(take);
  assign pos_ext  = {6'd0, bytes_out};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ins[i*8 +: 8] = 8'd0;
      if (kind == CMD_FILL && 4'(i) >= {1'b0, off} && 4'(i) < span_end) begin
        ins[i*8 +: 8] = FILL_BYTE;
      end else if (kind == CMD_LIT && 3'(i) == off) begin
        ins[i*8 +: 8] = value;
      end
    end
  end

  assign word_new  = word_buffer | ins;
  assign slot_free = !out_valid || pop;
  assign step      = active && (!emit || slot_free);
  assign load      = !active && !q_empty;
  assign q_pop     = load;
  assign empty     = !out_valid;
  assign result    = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      active      <= 1'b0;
      bytes_out   <= '0;
      word_buffer <= '0;
    end else if (load) begin
      active <= 1'b1;
      if (q_cmd.kind == CMD_FILL) begin
        bytes_out   <= '0;
        word_buffer <= '0;
      end
    end else if (step) begin
      bytes_out   <= last ? '0 : new_pos;
      word_buffer <= emit ? 64'd0 : word_new;
      if (last || cnt_rem == '0) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind  <= q_cmd.kind;
      value <= q_cmd.value;
      unique case (q_cmd.kind)
        CMD_ZERO: cnt <= CW'(q_cmd.value);
        CMD_FILL: cnt <= CW'(row_bytes);
        default:  cnt <= CW'(1);
      endcase
    end else if (step) begin
      cnt <= cnt_rem;
    end
    if (step && emit) begin
      out_word.vis_word   <= word_new;
      out_word.word_index <= pos_ext[8:3];
      out_word.row_last   <= last;
    end
  end

endmodule

@@ design/visibility_row_zero_rle_decoder.sv @@
// A literal byte that completes a word passes through the command queue, the back unit's
// command registers (load) and the output register (step) before it shows on the result port.
// The back unit takes one queued command at a time, a new one only when done with the last:
// a literal byte is one step, a zero run or full 0xff row one step per word touched; a waiting
// result word stalls the back unit, and the two-entry command queue then raises full.
// Reset (synchronous, active high) empties both queues, sets row_bytes to 1 and starts a row.
module visibility_row_zero_rle_decoder #(
  parameter int MAX_ROW_BYTES = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  vrz_pkg::item_t                item,
  output logic                          empty,
  input  logic                          pop,
  output vrz_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vrz_pkg::LEAF_W-1:0]    cfg_data
);
  import vrz_pkg::*;

  localparam int PW = $clog2(MAX_ROW_BYTES + 1);

  logic [PW-1:0] row_bytes;
  logic          cfg_we;
  logic [13:0]   leaf_sum;
  logic [31:0]   rb_ext;
  logic [PW-1:0] rb_clamped;

  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  cmd_t          q_wr_cmd;
  cmd_t          q_rd_cmd;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign leaf_sum  = {1'b0, cfg_data} + 14'd7;
  assign rb_ext    = 32'(leaf_sum[13:3]);

  always_comb begin
    priority if (rb_ext == 32'd0) begin
      rb_clamped = PW'(1);
    end else if (rb_ext > 32'(MAX_ROW_BYTES)) begin
      rb_clamped = PW'(MAX_ROW_BYTES);
    end else begin
      rb_clamped = rb_ext[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes <= PW'(1);
    end else if (cfg_we) begin
      row_bytes <= rb_clamped;
    end
  end

  vrz_front u_front (
    .clk    (clk),
    .rst    (rst),
    .clear  (cfg_we),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_wr_cmd)
  );

  vrz_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push),
    .wr_cmd (q_wr_cmd),
    .full   (q_full),
    .rd     (q_pop),
    .rd_cmd (q_rd_cmd),
    .empty  (q_empty)
  );

  vrz_back #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_we),
    .row_bytes (row_bytes),
    .q_empty   (q_empty),
    .q_cmd     (q_rd_cmd),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

@@ design/vrz_checker.sv @@
module vrz_checker #(
  parameter int MAX_ROW_BYTES = 512
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input vrz_pkg::result_t              result,
  input logic                          cfg_valid,
  input logic                          cfg_ready
);

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result word changed or vanished");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    ((MAX_ROW_BYTES <= 512) && !empty && !result.row_last) |-> (result.word_index != 6'd63))
    else $error("word 63 of a row not marked as last");

endmodule

bind visibility_row_zero_rle_decoder vrz_checker #(
  .MAX_ROW_BYTES(MAX_ROW_BYTES)
) u_vrz_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .result    (result),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

@@ tb/tb_visibility_row_zero_rle_decoder.sv @@
module tb_visibility_row_zero_rle_decoder;
  import vrz_pkg::*;

  class row_word_scoreboard;
    logic [LEAF_W-1:0] leaf_count;
    bit count_pending;
    int unsigned bytes_done;
    logic [63:0] partial_word;
    result_t pending_words[$];
    int errors;

    function new();
      leaf_count = 1;
      errors = 0;
      restart_row();
    endfunction

    function void restart_row();
      count_pending = 0;
      bytes_done = 0;
      partial_word = '0;
    endfunction

    function void set_leaf_count(logic [LEAF_W-1:0] value);
      leaf_count = value;
      restart_row();
    endfunction

    function int unsigned row_bytes();
      int unsigned r;
      r = (int'(leaf_count) + 7) >> 3;
      if (r < 1) r = 1;
      if (r > 512) r = 512;
      return r;
    endfunction

    function void put_byte(logic [7:0] b, int unsigned nbytes);
      int unsigned pos;
      result_t w;
      pos = bytes_done;
      partial_word |= 64'(b) << (8 * (pos % 8));
      bytes_done = pos + 1;
      if ((bytes_done % 8) == 0 || bytes_done >= nbytes) begin
        w.vis_word = partial_word;
        w.word_index = 6'(pos / 8);
        w.row_last = (bytes_done >= nbytes);
        pending_words.push_back(w);
        partial_word = '0;
        if (bytes_done >= nbytes) restart_row();
      end
    endfunction

    function void note_item(item_t it);
      int unsigned nbytes;
      int unsigned run;
      int unsigned prior;
      nbytes = row_bytes();
      if (it.mode) begin
        restart_row();
        for (int unsigned i = 0; i < nbytes; i++) put_byte(FILL_BYTE, nbytes);
      end else if (count_pending) begin
        count_pending = 0;
        run = it.data_byte;
        while (run > 0) begin
          prior = bytes_done;
          put_byte(8'h00, nbytes);
          run--;
          if (bytes_done == 0 && prior + 1 >= nbytes) break;
        end
      end else if (it.data_byte == 8'h00) begin
        count_pending = 1;
      end else begin
        put_byte(it.data_byte, nbytes);
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending_words.size() == 0) begin
        $error("unexpected word: vis_word %h word_index %0d row_last %0d",
               got.vis_word, got.word_index, got.row_last);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (got.vis_word !== want.vis_word) begin
        $error("vis_word mismatch: expected %h, actual %h", want.vis_word, got.vis_word);
        errors++;
      end
      if (got.word_index !== want.word_index) begin
        $error("word_index mismatch: expected %0d, actual %0d",
               want.word_index, got.word_index);
        errors++;
      end
      if (got.row_last !== want.row_last) begin
        $error("row_last mismatch: expected %0d, actual %0d", want.row_last, got.row_last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  item_t item = '0;
  logic empty;
  logic pop = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LEAF_W-1:0] cfg_data = '0;

  bit steady = 1'b0;
  int random_sent = 0;
  row_word_scoreboard sb = new();

  visibility_row_zero_rle_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_word(result);
      pop <= steady || ($urandom_range(99) >= 24);
    end
  end

  task automatic send_item(logic m, logic [7:0] b);
    item_t it;
    it.mode = m;
    it.data_byte = b;
    while (!steady && $urandom_range(99) < 24) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    sb.note_item(it);
  endtask

  task automatic drain_words();
    push <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_leaf_count(logic [LEAF_W-1:0] value);
    drain_words();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_leaf_count(value);
  endtask

  task automatic send_random_token();
    int unsigned pick;
    int unsigned run;
    pick = $urandom_range(99);
    if (pick < 68) begin
      send_item(1'b0, 8'($urandom_range(255, 1)));
      random_sent += 1;
    end else if (pick < 90) begin
      pick = $urandom_range(9);
      if (pick < 2) run = 0;
      else if (pick < 6) run = $urandom_range(9);
      else run = $urandom_range(255);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'(run));
      random_sent += 2;
    end else if (pick < 95) begin
      send_item(1'b1, 8'($urandom_range(255)));
      random_sent += 1;
    end else begin
      // A marker cut short by a full-row request.
      send_item(1'b0, 8'h00);
      send_item(1'b1, 8'($urandom_range(255)));
      random_sent += 2;
    end
  endtask

  initial begin
    int unsigned pick;
    int unsigned phase_len;
    logic [LEAF_W-1:0] leaves;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h05);
    send_item(1'b1, 8'h00);

    write_leaf_count(13'd0);
    send_item(1'b0, 8'hff);

    write_leaf_count(13'd20);
    send_item(1'b0, 8'h80);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hff);
    send_item(1'b0, 8'h7f);
    send_item(1'b1, 8'ha5);

    write_leaf_count(13'h1fff);
    send_item(1'b1, 8'hff);
    send_item(1'b0, 8'h55);

    write_leaf_count(13'd4096);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hff);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hff);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h02);

    while (random_sent < 250) begin
      pick = $urandom_range(99);
      if (pick < 8) leaves = 13'($urandom_range(8191, 4096));
      else if (pick < 12) leaves = '0;
      else leaves = 13'($urandom_range(160, 1));
      write_leaf_count(leaves);
      phase_len = $urandom_range(40, 15);
      for (int unsigned i = 0; i < phase_len && random_sent < 250; i++) begin
        steady = (random_sent >= 100 && random_sent < 160);
        send_random_token();
      end
    end
    steady = 1'b0;

    drain_words();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
